// ----- rtl/assert_macros.svh -----
// Assertion macros used by the reconnect backoff tracker RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, skip while reset is asserted
`define RBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, including reset cycles
`define RBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/rbt_pkg.sv -----
// Shared types, codes and constants of the reconnect backoff tracker.
// No dependencies; imported by every RTL module of the block.
package rbt_pkg;

  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned HIST_BITS_DEF = 27;

  localparam int unsigned ENTRY_W = 4;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned FRUN_W  = 5;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [FRUN_W-1:0] ATT_MAX = 5'd31;
  localparam logic [CNT_W-1:0]  CNT_MAX = 8'd255;

  localparam logic [WAIT_W-1:0] STEADY_DEF  = 16'd300;
  localparam logic [WAIT_W-1:0] FAST_DEF    = 16'd1;
  localparam logic [WAIT_W-1:0] UNVER_DEF   = 16'd30;
  localparam logic [WAIT_W-1:0] PIN_CAP_DEF = 16'd20;
  localparam logic [WAIT_W-1:0] GEN_CAP_DEF = 16'd1800;

  typedef enum logic [1:0] {
    OP_ACTIVATE    = 2'd0,
    OP_ESTABLISHED = 2'd1,
    OP_ENDED       = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    OC_NEVER  = 2'd0,
    OC_UNINIT = 2'd1,
    OC_INIT   = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    REG_STEADY  = 3'd0,
    REG_FAST    = 3'd1,
    REG_UNVER   = 3'd2,
    REG_PIN_CAP = 3'd3,
    REG_GEN_CAP = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RUN,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [WAIT_W-1:0] steady;
    logic [WAIT_W-1:0] fast;
    logic [WAIT_W-1:0] unver;
    logic [WAIT_W-1:0] pin_cap;
    logic [WAIT_W-1:0] gen_cap;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic run;
    logic load_out;
  } cmd_t;

endpackage

// ----- rtl/rbt_cfg.sv -----
// APB-style register bank holding the wait and cap settings.
// Depends on rbt_pkg.
module rbt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbt_pkg::PADDR_W-1:0] paddr,
  input  logic [rbt_pkg::PDATA_W-1:0] pwdata,
  output logic [rbt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output rbt_pkg::cfg_t               cfg
);
  import rbt_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] ridx;

  assign ridx   = paddr[PADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (ridx)
        REG_STEADY:  cfg_nxt.steady  = pwdata[WAIT_W-1:0];
        REG_FAST:    cfg_nxt.fast    = pwdata[WAIT_W-1:0];
        REG_UNVER:   cfg_nxt.unver   = pwdata[WAIT_W-1:0];
        REG_PIN_CAP: cfg_nxt.pin_cap = pwdata[WAIT_W-1:0];
        REG_GEN_CAP: cfg_nxt.gen_cap = pwdata[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_STEADY:  prdata = {{(PDATA_W-WAIT_W){1'b0}}, cfg_r.steady};
      REG_FAST:    prdata = {{(PDATA_W-WAIT_W){1'b0}}, cfg_r.fast};
      REG_UNVER:   prdata = {{(PDATA_W-WAIT_W){1'b0}}, cfg_r.unver};
      REG_PIN_CAP: prdata = {{(PDATA_W-WAIT_W){1'b0}}, cfg_r.pin_cap};
      REG_GEN_CAP: prdata = {{(PDATA_W-WAIT_W){1'b0}}, cfg_r.gen_cap};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{steady: STEADY_DEF, fast: FAST_DEF, unver: UNVER_DEF,
                 pin_cap: PIN_CAP_DEF, gen_cap: GEN_CAP_DEF};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/rbt_ctrl.sv -----
// Sequencing controller: capture, update, failure run, wait and output load.
// Depends on rbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rbt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rbt_pkg::cmd_t cmd
);
  import rbt_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RUN;
      end
      ST_RUN: begin
        cmd.run   = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `RBT_ASSERT(a_capture_then_update, (in_valid && in_ready) |=> cmd.update, "no update after capture")
  `RBT_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid || out_ready), "pending beat overwritten")
  `RBT_ASSERT(a_load_shows_beat, cmd.load_out |=> out_valid, "loaded beat not presented")
  `RBT_ASSERT_ALWAYS(a_no_accept_while_busy, (in_ready |-> !cmd.update), "accept during update")

endmodule

// ----- rtl/rbt_dpath.sv -----
// Datapath: per-entry tracker store, read-modify-write, failure run and wait.
// Depends on rbt_pkg; driven by rbt_ctrl commands and rbt_cfg settings.
module rbt_dpath #(
  parameter int unsigned ENTRIES      = rbt_pkg::ENTRIES_DEF,
  parameter int unsigned HISTORY_BITS = rbt_pkg::HIST_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rbt_pkg::cmd_t              cmd,
  input  rbt_pkg::cfg_t              cfg,
  input  logic [1:0]                 in_operation,
  input  logic [rbt_pkg::ENTRY_W-1:0] in_entry,
  input  logic [1:0]                 in_outcome,
  input  logic                       in_peer_verified,
  input  logic                       in_peer_pinned,
  input  logic [rbt_pkg::WAIT_W-1:0] in_prev_wait_sec,
  output logic                       out_request_issued,
  output logic                       out_wait_valid,
  output logic [rbt_pkg::WAIT_W-1:0] out_wait_sec,
  output logic [rbt_pkg::FRUN_W-1:0] out_fail_run,
  output logic                       out_last_failed,
  output logic [rbt_pkg::CNT_W-1:0]  out_open_count,
  output logic                       out_error
);
  import rbt_pkg::*;

  localparam int unsigned REACH = 1 << ENTRY_W;
  localparam int unsigned DEPTH = (ENTRIES < REACH) ? ENTRIES : REACH;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ENTRY_W:0] LIMIT = (ENTRY_W + 1)'(DEPTH);

  // entry store
  logic [HISTORY_BITS-1:0] hist_r [DEPTH];
  logic [FRUN_W-1:0]       att_r  [DEPTH];
  logic                    pend_r [DEPTH];
  logic [CNT_W-1:0]        cnt_r  [DEPTH];

  // captured item
  logic [1:0]         op_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [1:0]         outcome_r;
  logic               verified_r;
  logic               pinned_r;
  logic [WAIT_W-1:0]  prev_r;

  // update stage
  logic [IDX_W-1:0]        idx;
  logic                    in_rng;
  logic [HISTORY_BITS-1:0] cur_h;
  logic [FRUN_W-1:0]       cur_a;
  logic                    cur_p;
  logic [CNT_W-1:0]        cur_c;
  logic                    rec;
  logic                    succ;
  logic [HISTORY_BITS:0]   hshift;
  logic [HISTORY_BITS-1:0] h_nxt;
  logic [FRUN_W-1:0]       a_nxt;
  logic                    p_nxt;
  logic [CNT_W-1:0]        c_nxt;
  logic                    iss_nxt;
  logic                    err_nxt;

  logic [HISTORY_BITS-1:0] h_r;
  logic [FRUN_W-1:0]       a_r;
  logic [CNT_W-1:0]        c_r;
  logic                    iss_r;
  logic                    err_r;
  logic                    rng_r;

  // failure run stage
  logic [FRUN_W-1:0] tz;
  logic [FRUN_W-1:0] frun_nxt;
  logic [FRUN_W-1:0] frun_r;

  // wait stage
  logic [WAIT_W:0]   dbl;
  logic [WAIT_W-1:0] cap;
  logic [WAIT_W-1:0] wait_nxt;
  logic              wvalid;

  logic              issued_o_r;
  logic              wvalid_o_r;
  logic [WAIT_W-1:0] wait_o_r;
  logic [FRUN_W-1:0] frun_o_r;
  logic              lastf_o_r;
  logic [CNT_W-1:0]  cnt_o_r;
  logic              err_o_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      entry_r    <= in_entry;
      outcome_r  <= in_outcome;
      verified_r <= in_peer_verified;
      pinned_r   <= in_peer_pinned;
      prev_r     <= in_prev_wait_sec;
    end
  end

  assign idx    = entry_r[IDX_W-1:0];
  assign in_rng = {1'b0, entry_r} < LIMIT;
  assign cur_h  = hist_r[idx];
  assign cur_a  = att_r[idx];
  assign cur_p  = pend_r[idx];
  assign cur_c  = cnt_r[idx];

  always_comb begin
    rec     = 1'b0;
    succ    = 1'b0;
    p_nxt   = cur_p;
    c_nxt   = cur_c;
    iss_nxt = 1'b0;
    err_nxt = 1'b0;
    case (op_r)
      OP_ACTIVATE: begin
        p_nxt   = 1'b1;
        iss_nxt = !cur_p;
      end
      OP_ESTABLISHED: begin
        p_nxt = 1'b0;
        rec   = 1'b1;
        succ  = 1'b1;
        if (cur_c != CNT_MAX) begin
          c_nxt = cur_c + 8'd1;
        end
      end
      OP_ENDED: begin
        p_nxt   = 1'b0;
        err_nxt = !cur_p;
        if (outcome_r == OC_NEVER) begin
          rec = 1'b1;
        end else begin
          if (cur_c == '0) begin
            err_nxt = 1'b1;
          end else begin
            c_nxt = cur_c - 8'd1;
          end
          if (outcome_r == OC_UNINIT) begin
            rec = 1'b1;
          end
        end
      end
      default: ;
    endcase
    hshift = {cur_h, succ};
    h_nxt  = rec ? hshift[HISTORY_BITS-1:0] : cur_h;
    a_nxt  = (rec && cur_a != ATT_MAX) ? cur_a + 5'd1 : cur_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_r[i] <= '0;
        att_r[i]  <= '0;
        pend_r[i] <= 1'b0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.update && in_rng) begin
      hist_r[idx] <= h_nxt;
      att_r[idx]  <= a_nxt;
      pend_r[idx] <= p_nxt;
      cnt_r[idx]  <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      h_r   <= h_nxt;
      a_r   <= a_nxt;
      c_r   <= c_nxt;
      iss_r <= iss_nxt;
      err_r <= err_nxt;
      rng_r <= in_rng;
    end
  end

  // trailing zeros of the history, bounded by the attempt count
  always_comb begin
    tz = '0;
    for (int i = HISTORY_BITS - 1; i >= 0; i--) begin
      if (h_r[i]) begin
        tz = FRUN_W'(i);
      end
    end
    if (h_r == '0) begin
      frun_nxt = a_r;
    end else begin
      frun_nxt = (tz < a_r) ? tz : a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      frun_r <= frun_nxt;
    end
  end

  always_comb begin
    dbl    = (prev_r == '0) ? 17'd1 : {prev_r, 1'b0};
    cap    = pinned_r ? cfg.pin_cap : cfg.gen_cap;
    wvalid = rng_r && (op_r == OP_ENDED);
    if (frun_r == 5'd0 && verified_r) begin
      wait_nxt = cfg.steady;
    end else if (frun_r == 5'd1) begin
      wait_nxt = (verified_r || pinned_r) ? cfg.fast : cfg.unver;
    end else begin
      wait_nxt = (dbl < {1'b0, cap}) ? dbl[WAIT_W-1:0] : cap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      issued_o_r <= rng_r && iss_r;
      wvalid_o_r <= wvalid;
      wait_o_r   <= wvalid ? wait_nxt : '0;
      frun_o_r   <= rng_r ? frun_r : '0;
      lastf_o_r  <= rng_r && !h_r[0];
      cnt_o_r    <= rng_r ? c_r : '0;
      err_o_r    <= rng_r && err_r;
    end
  end

  assign out_request_issued = issued_o_r;
  assign out_wait_valid     = wvalid_o_r;
  assign out_wait_sec       = wait_o_r;
  assign out_fail_run       = frun_o_r;
  assign out_last_failed    = lastf_o_r;
  assign out_open_count     = cnt_o_r;
  assign out_error          = err_o_r;

endmodule

// ----- rtl/reconnect_backoff_tracker_top.sv -----
// Capture, store update, failure-run count and wait computation each take one
// step of the sequencer, in that order, before out_valid rises; a new item is
// accepted only when the sequencer is idle, and the output load waits while an unaccepted result beat is pending.
// The output register frees the input side while a result beat waits.
// Reset (synchronous, rst_n low) clears every tracker entry at once and loads
// the default waits and caps; no clearing pass follows.
module reconnect_backoff_tracker_top #(
  parameter int unsigned ENTRIES      = rbt_pkg::ENTRIES_DEF,
  parameter int unsigned HISTORY_BITS = rbt_pkg::HIST_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [rbt_pkg::ENTRY_W-1:0] in_entry,
  input  logic [1:0]                  in_outcome,
  input  logic                        in_peer_verified,
  input  logic                        in_peer_pinned,
  input  logic [rbt_pkg::WAIT_W-1:0]  in_prev_wait_sec,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_request_issued,
  output logic                        out_wait_valid,
  output logic [rbt_pkg::WAIT_W-1:0]  out_wait_sec,
  output logic [rbt_pkg::FRUN_W-1:0]  out_fail_run,
  output logic                        out_last_failed,
  output logic [rbt_pkg::CNT_W-1:0]   out_open_count,
  output logic                        out_error,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rbt_pkg::PADDR_W-1:0] paddr,
  input  logic [rbt_pkg::PDATA_W-1:0] pwdata,
  output logic [rbt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import rbt_pkg::*;

  cmd_t cmd;
  cfg_t cfg;

  rbt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rbt_dpath #(
    .ENTRIES      (ENTRIES),
    .HISTORY_BITS (HISTORY_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_operation       (in_operation),
    .in_entry           (in_entry),
    .in_outcome         (in_outcome),
    .in_peer_verified   (in_peer_verified),
    .in_peer_pinned     (in_peer_pinned),
    .in_prev_wait_sec   (in_prev_wait_sec),
    .out_request_issued (out_request_issued),
    .out_wait_valid     (out_wait_valid),
    .out_wait_sec       (out_wait_sec),
    .out_fail_run       (out_fail_run),
    .out_last_failed    (out_last_failed),
    .out_open_count     (out_open_count),
    .out_error          (out_error)
  );

endmodule
